// ----- hw/rtl/trrs_pkg.sv -----
// Shared types and constants for the two-level round-robin scheduler.
// No dependencies; trrs_dpath, trrs_ctrl and the top level refer to this package by scoped names.
`default_nettype none

package trrs_pkg;

    localparam int MAX_PROCS_DEF    = 16;
    localparam int THREAD_SLOTS_DEF = 8;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_SCHEDULE = 3'd0;
    localparam logic [2:0] CMD_CREATE   = 3'd1;
    localparam logic [2:0] CMD_ADD      = 3'd2;
    localparam logic [2:0] CMD_SET      = 3'd3;
    localparam logic [2:0] CMD_EXIT     = 3'd4;

    // Thread status codes; anything above ST_ZOMBIE means blocked.
    localparam logic [2:0] ST_READY   = 3'd0;
    localparam logic [2:0] ST_RUNNING = 3'd1;
    localparam logic [2:0] ST_ZOMBIE  = 3'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] process_index;
        logic [2:0] thread_index;
        logic [2:0] new_status;
    } t_in;

    typedef struct packed {
        logic       found;
        logic [3:0] chosen_process;
        logic [2:0] chosen_thread;
        logic       error;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ZAP,
        S_NEXT_PROC,
        S_PROC_INIT,
        S_CHECK,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_WALK_START,
        DP_CREATE,
        DP_ADD,
        DP_SET,
        DP_EXIT,
        DP_ZAP,
        DP_NEXT_PROC,
        DP_PROC_INIT,
        DP_STEP,
        DP_HIT,
        DP_PUSH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctrl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       live_zero;
        logic       exit_err;
        logic       proc_empty;
        logic       walk_done;
        logic       runnable;
        logic       wrap_to_cur;
        logic       zap_last;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hw/rtl/trrs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module trrs_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/trrs_dpath.sv -----
// Scheduler datapath: process and thread tables, walk pointers, result and output registers.
// Depends on trrs_pkg and trrs_ram (thread status store).
`default_nettype none

module trrs_dpath #(
    parameter int MAX_PROCS    = trrs_pkg::MAX_PROCS_DEF,
    parameter int THREAD_SLOTS = trrs_pkg::THREAD_SLOTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire trrs_pkg::t_dp_ctrl   i_ctrl,
    output trrs_pkg::t_dp_status      o_status,
    input  wire trrs_pkg::t_in        i_in_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output trrs_pkg::t_out            o_out_data
);

    localparam int PW    = $clog2(MAX_PROCS);
    localparam int TW    = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int CPW   = $clog2(MAX_PROCS + 1);
    localparam int TCW   = $clog2(THREAD_SLOTS + 1);
    localparam int PXW   = (CPW > 4) ? CPW : 4;
    localparam int TXW   = (TCW > 3) ? TCW : 3;
    localparam int AW    = PW + TW;
    localparam int DEPTH = MAX_PROCS << TW;

    logic [CPW-1:0] r_live, n_live;
    logic [PW-1:0]  r_curp, n_curp;
    logic [TCW-1:0] r_tip [MAX_PROCS];
    logic [TW-1:0]  r_ctp [MAX_PROCS];

    logic [2:0]     r_cmd, n_cmd;
    logic [3:0]     r_pin, n_pin;
    logic [2:0]     r_tin, n_tin;
    logic [2:0]     r_st, n_st;
    logic [PW-1:0]  r_proc, n_proc;
    logic [TW-1:0]  r_thr, n_thr;
    logic [CPW-1:0] r_walk, n_walk;
    trrs_pkg::t_out r_res, n_res;
    logic           r_out_valid, n_out_valid;
    trrs_pkg::t_out r_out, n_out;

    logic           tip_we;
    logic [TCW-1:0] tip_wdata;
    logic           ctp_we;
    logic [TW-1:0]  ctp_wdata;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [2:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [2:0]     ram_rdata;

    logic [TCW-1:0] thr_cnt;
    logic [TW-1:0]  cur_thr;
    logic           p_bad;
    logic           create_err;
    logic           add_err;
    logic           set_err;
    logic [TW:0]    cur_inc;
    logic [TW-1:0]  first_idx;
    logic [TW:0]    thr_inc;
    logic [TW-1:0]  step_idx;
    logic [CPW-1:0] proc_inc;
    logic [PW-1:0]  next_proc;
    logic           out_free;

    assign thr_cnt    = r_tip[r_proc];
    assign cur_thr    = r_ctp[r_proc];
    assign p_bad      = PXW'(r_pin) >= PXW'(r_live);
    assign create_err = r_live >= CPW'(MAX_PROCS);
    assign add_err    = p_bad || (thr_cnt >= TCW'(THREAD_SLOTS));
    assign set_err    = p_bad || (TXW'(r_tin) >= TXW'(thr_cnt));

    // Both thread searches step one slot forward and wrap at the thread count.
    assign cur_inc   = (TW+1)'(cur_thr) + (TW+1)'(1);
    assign first_idx = (cur_inc >= (TW+1)'(thr_cnt)) ? '0 : TW'(cur_inc);
    assign thr_inc   = (TW+1)'(r_thr) + (TW+1)'(1);
    assign step_idx  = (thr_inc >= (TW+1)'(thr_cnt)) ? '0 : TW'(thr_inc);

    assign proc_inc  = CPW'(r_curp) + CPW'(1);
    assign next_proc = (proc_inc >= r_live) ? '0 : PW'(proc_inc);

    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.cmd         = r_cmd;
        o_status.live_zero   = (r_live == '0);
        o_status.exit_err    = p_bad;
        o_status.proc_empty  = (thr_cnt == '0);
        o_status.walk_done   = (r_walk == r_live);
        o_status.runnable    = (ram_rdata == trrs_pkg::ST_READY) ||
                               (ram_rdata == trrs_pkg::ST_RUNNING);
        o_status.wrap_to_cur = (step_idx == cur_thr);
        o_status.zap_last    = (thr_inc == (TW+1)'(thr_cnt));
        o_status.out_free    = out_free;
    end

    always_comb begin
        n_live      = r_live;
        n_curp      = r_curp;
        n_cmd       = r_cmd;
        n_pin       = r_pin;
        n_tin       = r_tin;
        n_st        = r_st;
        n_proc      = r_proc;
        n_thr       = r_thr;
        n_walk      = r_walk;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        tip_we      = 1'b0;
        tip_wdata   = thr_cnt;
        ctp_we      = 1'b0;
        ctp_wdata   = cur_thr;
        ram_we      = 1'b0;
        ram_waddr   = {r_proc, r_thr};
        ram_wdata   = trrs_pkg::ST_READY;
        ram_raddr   = {r_proc, r_thr};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (i_ctrl.op)
            trrs_pkg::DP_LOAD: begin
                n_cmd = i_in_data.cmd;
                n_pin = i_in_data.process_index;
                n_tin = i_in_data.thread_index;
                n_st  = i_in_data.new_status;
                if (i_in_data.cmd == trrs_pkg::CMD_CREATE) begin
                    n_proc = PW'(r_live);
                end else begin
                    n_proc = PW'(i_in_data.process_index);
                end
                n_res = '0;
            end
            trrs_pkg::DP_WALK_START: begin
                n_walk = '0;
            end
            trrs_pkg::DP_CREATE: begin
                if (create_err) begin
                    n_res.error = 1'b1;
                end else begin
                    n_live               = r_live + CPW'(1);
                    tip_we               = 1'b1;
                    tip_wdata            = TCW'(1);
                    ctp_we               = 1'b1;
                    ctp_wdata            = '0;
                    ram_we               = 1'b1;
                    ram_waddr            = {r_proc, TW'(0)};
                    ram_wdata            = trrs_pkg::ST_READY;
                    n_res.chosen_process = 4'(r_proc);
                end
            end
            trrs_pkg::DP_ADD: begin
                if (add_err) begin
                    n_res.error = 1'b1;
                end else begin
                    tip_we               = 1'b1;
                    tip_wdata            = thr_cnt + TCW'(1);
                    ram_we               = 1'b1;
                    ram_waddr            = {r_proc, TW'(thr_cnt)};
                    ram_wdata            = trrs_pkg::ST_READY;
                    n_res.chosen_process = 4'(r_proc);
                    n_res.chosen_thread  = 3'(thr_cnt);
                end
            end
            trrs_pkg::DP_SET: begin
                if (set_err) begin
                    n_res.error = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_proc, TW'(r_tin)};
                    ram_wdata = r_st;
                end
            end
            trrs_pkg::DP_EXIT: begin
                if (p_bad) begin
                    n_res.error = 1'b1;
                end
                n_thr  = '0;
                n_walk = '0;
            end
            trrs_pkg::DP_ZAP: begin
                ram_we    = 1'b1;
                ram_waddr = {r_proc, r_thr};
                ram_wdata = trrs_pkg::ST_ZOMBIE;
                n_thr     = TW'(thr_inc);
            end
            trrs_pkg::DP_NEXT_PROC: begin
                n_curp = next_proc;
                n_proc = next_proc;
                n_walk = r_walk + CPW'(1);
            end
            trrs_pkg::DP_PROC_INIT: begin
                n_thr     = first_idx;
                ram_raddr = {r_proc, first_idx};
            end
            trrs_pkg::DP_STEP: begin
                n_thr     = step_idx;
                ram_raddr = {r_proc, step_idx};
            end
            trrs_pkg::DP_HIT: begin
                ram_we               = 1'b1;
                ram_waddr            = {r_proc, r_thr};
                ram_wdata            = trrs_pkg::ST_RUNNING;
                ctp_we               = 1'b1;
                ctp_wdata            = r_thr;
                n_res.found          = 1'b1;
                n_res.chosen_process = 4'(r_proc);
                n_res.chosen_thread  = 3'(r_thr);
            end
            trrs_pkg::DP_PUSH: begin
                n_out       = r_res;
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_curp      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) begin
                r_tip[i] <= '0;
                r_ctp[i] <= '0;
            end
        end else begin
            r_live      <= n_live;
            r_curp      <= n_curp;
            r_out_valid <= n_out_valid;
            if (tip_we) begin
                r_tip[r_proc] <= tip_wdata;
            end
            if (ctp_we) begin
                r_ctp[r_proc] <= ctp_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_pin  <= n_pin;
        r_tin  <= n_tin;
        r_st   <= n_st;
        r_proc <= n_proc;
        r_thr  <= n_thr;
        r_walk <= n_walk;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    trrs_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/trrs_ctrl.sv -----
// Scheduler controller: state machine that sequences each command through the datapath.
// Depends on trrs_pkg.
`default_nettype none

module trrs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire trrs_pkg::t_dp_status i_status,
    output trrs_pkg::t_dp_ctrl        o_ctrl
);

    trrs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl.op  = trrs_pkg::DP_NOP;
        o_in_ready = 1'b0;

        case (r_state)
            trrs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.op = trrs_pkg::DP_LOAD;
                    n_state   = trrs_pkg::S_DECODE;
                end
            end
            trrs_pkg::S_DECODE: begin
                case (i_status.cmd)
                    trrs_pkg::CMD_SCHEDULE: begin
                        o_ctrl.op = trrs_pkg::DP_WALK_START;
                        n_state   = i_status.live_zero ? trrs_pkg::S_DONE
                                                       : trrs_pkg::S_NEXT_PROC;
                    end
                    trrs_pkg::CMD_CREATE: begin
                        o_ctrl.op = trrs_pkg::DP_CREATE;
                        n_state   = trrs_pkg::S_DONE;
                    end
                    trrs_pkg::CMD_ADD: begin
                        o_ctrl.op = trrs_pkg::DP_ADD;
                        n_state   = trrs_pkg::S_DONE;
                    end
                    trrs_pkg::CMD_SET: begin
                        o_ctrl.op = trrs_pkg::DP_SET;
                        n_state   = trrs_pkg::S_DONE;
                    end
                    trrs_pkg::CMD_EXIT: begin
                        o_ctrl.op = trrs_pkg::DP_EXIT;
                        if (i_status.exit_err) begin
                            n_state = trrs_pkg::S_DONE;
                        end else if (i_status.proc_empty) begin
                            n_state = trrs_pkg::S_NEXT_PROC;
                        end else begin
                            n_state = trrs_pkg::S_ZAP;
                        end
                    end
                    default: begin
                        n_state = trrs_pkg::S_DONE;
                    end
                endcase
            end
            trrs_pkg::S_ZAP: begin
                o_ctrl.op = trrs_pkg::DP_ZAP;
                if (i_status.zap_last) begin
                    n_state = trrs_pkg::S_NEXT_PROC;
                end
            end
            trrs_pkg::S_NEXT_PROC: begin
                // Every live process has been visited once when the walk count reaches the total.
                if (i_status.walk_done) begin
                    n_state = trrs_pkg::S_DONE;
                end else begin
                    o_ctrl.op = trrs_pkg::DP_NEXT_PROC;
                    n_state   = trrs_pkg::S_PROC_INIT;
                end
            end
            trrs_pkg::S_PROC_INIT: begin
                if (i_status.proc_empty) begin
                    n_state = trrs_pkg::S_NEXT_PROC;
                end else begin
                    o_ctrl.op = trrs_pkg::DP_PROC_INIT;
                    n_state   = trrs_pkg::S_CHECK;
                end
            end
            trrs_pkg::S_CHECK: begin
                if (i_status.runnable) begin
                    o_ctrl.op = trrs_pkg::DP_HIT;
                    n_state   = trrs_pkg::S_DONE;
                end else if (i_status.wrap_to_cur) begin
                    n_state = trrs_pkg::S_NEXT_PROC;
                end else begin
                    o_ctrl.op = trrs_pkg::DP_STEP;
                end
            end
            trrs_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_ctrl.op = trrs_pkg::DP_PUSH;
                    n_state   = trrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = trrs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/two_level_round_robin_scheduler.sv -----
// Top level of the two-level round-robin scheduler: controller plus datapath.
// Depends on trrs_pkg, trrs_ctrl, trrs_dpath (and trrs_ram below it).
//
//   Channel   Direction   Handshake                    Payload
//   in        consumer    i_in_valid / o_in_ready      i_in_data  (trrs_pkg::t_in)
//   out       producer    o_out_valid / i_out_ready    o_out_data (trrs_pkg::t_out)
//
// Create, add thread, set status and unknown commands go from acceptance through decode to the done state.
// Schedule walks the live processes in turn and searches the thread slots of each, reading one status
// entry a cycle from the single read port of the status memory; a walk over a non-empty table
// that finds nothing runnable ends in the done state with found clear.
// Exit marks every thread of the process zombie in turn, before its schedule pass.
// Reset is synchronous and clears the counters and per-process tables at once; the status
// memory is not cleared, as only slots that have been written are ever read.
// A new transaction is taken while a finished result still waits in the output register;
// the following result then holds the block in its last state until that register frees.

`default_nettype none

module two_level_round_robin_scheduler #(
    parameter int MAX_PROCS    = trrs_pkg::MAX_PROCS_DEF,
    parameter int THREAD_SLOTS = trrs_pkg::THREAD_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire trrs_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output trrs_pkg::t_out      o_out_data
);

    trrs_pkg::t_dp_ctrl   ctrl;
    trrs_pkg::t_dp_status status;

    trrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    trrs_dpath #(
        .MAX_PROCS    (MAX_PROCS),
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
